### src/sha384_pkg.sv
// sha384_pkg: constants, types and round functions for the sha-384 stream hasher
// no dependencies
package sha384_pkg;

  localparam int WordW   = 64;
  localparam int Rounds  = 80;
  localparam int DigestN = 6;

  typedef logic [63:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } core_ctl_t;

  function automatic word_t rotr(word_t x, int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t init_hash(logic [2:0] i);
    case (i)
      3'd0: init_hash = 64'hcbbb9d5dc1059ed8;
      3'd1: init_hash = 64'h629a292a367cd507;
      3'd2: init_hash = 64'h9159015a3070dd17;
      3'd3: init_hash = 64'h152fecd8f70e5939;
      3'd4: init_hash = 64'h67332667ffc00b31;
      3'd5: init_hash = 64'h8eb44a8768581511;
      3'd6: init_hash = 64'hdb0c2e0d64f98fa7;
      default: init_hash = 64'h47b5481dbefa4fa4;
    endcase
  endfunction

  function automatic word_t round_k(logic [6:0] t);
    case (t)
      7'd0: round_k = 64'h428a2f98d728ae22; 7'd1: round_k = 64'h7137449123ef65cd;
      7'd2: round_k = 64'hb5c0fbcfec4d3b2f; 7'd3: round_k = 64'he9b5dba58189dbbc;
      7'd4: round_k = 64'h3956c25bf348b538; 7'd5: round_k = 64'h59f111f1b605d019;
      7'd6: round_k = 64'h923f82a4af194f9b; 7'd7: round_k = 64'hab1c5ed5da6d8118;
      7'd8: round_k = 64'hd807aa98a3030242; 7'd9: round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = 64'h0;
    endcase
  endfunction

endpackage

### src/sha384_if.sv
// sha384_if: valid/ready stream channels for message and digest words
// depends on no other file
interface sha384_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [63:0] msg_word;
  logic [3:0]  bytes_valid;
  logic        is_last;
  modport source (output valid, msg_word, bytes_valid, is_last, input ready);
  modport sink (input valid, msg_word, bytes_valid, is_last, output ready);
endinterface

interface sha384_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### src/sha384_stream_hasher_unit.sv
// sha384_stream_hasher_unit: sha-384 over a stream of 64-bit message words
// depends on sha384_pkg, sha384_if, sha384_core
// a word that completes a block holds the input while its bytes are pushed and the core compresses the block
// other words hold the input only while their bytes are pushed, one byte per cycle, before ready returns
// words are taken only in idle, so byte loading and the single round unit set the throughput
// last word: one pad byte per cycle outside compression, two length loads, one or two blocks, then 6 digest words
// reset: synchronous, chaining value back to the sha-384 initial hash
module sha384_stream_hasher_unit (
  input logic             clk,
  input logic             rst,
  sha384_in_if.sink       in_ch,
  sha384_out_if.source    out_ch
);
  import sha384_pkg::*;

  state_t      state, state_next;
  logic [63:0] word_r;       // held input word, shifted one byte per cycle in ST_LOAD
  logic [3:0]  cnt;          // bytes left to push from word_r
  logic        last_r;
  logic [63:0] partial;
  logic [6:0]  fill;
  logic [63:0] blocks;
  logic [63:0] len_lo, len_hi;
  logic [2:0]  oidx;
  logic        pad_started;  // 0x80 byte pushed
  logic        pad_done;     // padding has reached the length field
  logic        final_blk;    // block being compressed carries the length
  logic        core_busy, core_done, core_start, core_load;
  logic [3:0]  core_lidx;
  word_t       core_ldata, core_rd;
  logic        restart;
  logic [7:0]  byte_in;
  logic        push;
  logic [63:0] merged;
  logic [1:0]  lenw;         // length word load step: high word, low word, start

  sha384_core u_core (
    .clk(clk), .rst(rst), .start(core_start), .load_w(core_load),
    .load_idx(core_lidx), .load_data(core_ldata), .restart(restart),
    .busy(core_busy), .done(core_done), .rd_idx(oidx), .rd_data(core_rd)
  );

  assign pad_done = pad_started && fill == 7'd112;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_ch.valid) state_next = ST_LOAD;
      ST_LOAD: begin
        // byte pushing; a full block starts the core
        if (fill == 7'd127 && push) state_next = ST_ROUND;
        else if (cnt == 4'd0 && !last_r) state_next = ST_IDLE;
        else if (cnt == 4'd0 && last_r) state_next = ST_PAD;
      end
      ST_PAD: begin
        // the 0x80 byte always goes in, even at byte 112
        if (pad_done && lenw == 2'd2) state_next = ST_ROUND;
        else if (fill == 7'd127 && push) state_next = ST_ROUND;
      end
      ST_ROUND: if (core_done) state_next = final_blk ? ST_EMIT :
                                   (last_r && cnt == 4'd0) ? ST_PAD :
                                   (cnt == 4'd0) ? ST_IDLE : ST_LOAD;
      ST_EMIT: if (out_ch.ready && oidx == 3'(DigestN - 1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    push    = 1'b0;
    byte_in = 8'h00;
    if (state == ST_LOAD && cnt != 4'd0) begin
      push    = 1'b1;
      byte_in = word_r[63:56];
    end else if (state == ST_PAD && !pad_done) begin
      push    = 1'b1;
      byte_in = pad_started ? 8'h00 : 8'h80;
    end
    merged = partial | (64'(byte_in) << ({3'd7 - fill[2:0], 3'b000}));
    // length words fill schedule slots 14 and 15 before the final block starts
    if (state == ST_PAD && pad_done) begin
      core_load  = (lenw != 2'd2);
      core_lidx  = (lenw == 2'd0) ? 4'd14 : 4'd15;
      core_ldata = (lenw == 2'd0) ? len_hi : len_lo;
    end else begin
      core_load  = push && fill[2:0] == 3'd7;
      core_lidx  = fill[6:3];
      core_ldata = merged;
    end
    core_start = push && fill == 7'd127 ||
                 (state == ST_PAD && pad_done && lenw == 2'd2);
    in_ch.ready = (state == ST_IDLE);
    out_ch.valid       = (state == ST_EMIT);
    out_ch.digest_word = core_rd;
    out_ch.word_index  = oidx;
    out_ch.last_word   = (oidx == 3'(DigestN - 1));
    restart = (state == ST_EMIT) && out_ch.ready && oidx == 3'(DigestN - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      partial <= '0; fill <= '0; blocks <= '0; cnt <= '0;
      oidx <= '0; pad_started <= 1'b0; final_blk <= 1'b0; last_r <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_ch.valid) begin
        word_r <= in_ch.msg_word;
        cnt    <= (in_ch.bytes_valid > 4'd8) ? 4'd8 : in_ch.bytes_valid;
        last_r <= in_ch.is_last;
      end
      if (push) begin
        if (state == ST_LOAD) begin
          word_r <= word_r << 8;
          cnt    <= cnt - 4'd1;
        end else begin
          pad_started <= 1'b1;
        end
        partial <= (fill[2:0] == 3'd7) ? 64'h0 : merged;
        fill    <= fill + 7'd1;
      end
      // length latched in the first padding cycle, block count already settled
      if (state == ST_PAD && !pad_started) begin
        len_lo <= {blocks[53:0], 10'd0} + {54'd0, fill, 3'd0};
        len_hi <= {54'd0, blocks[63:54]} +
                  64'(({blocks[53:0], 10'd0} + {54'd0, fill, 3'd0}) <
                      {blocks[53:0], 10'd0});
      end
      if (state == ST_PAD && pad_done) final_blk <= 1'b1;
      if (core_done) blocks <= blocks + 64'd1;
      if (restart) begin
        oidx <= '0;
      end else if (state == ST_EMIT && out_ch.ready) begin
        oidx <= oidx + 3'd1;
      end
      if (restart) begin
        partial <= '0; fill <= '0; blocks <= '0; cnt <= '0;
        pad_started <= 1'b0; final_blk <= 1'b0; last_r <= 1'b0;
      end
    end
  end

  // length load sequencing
  always_ff @(posedge clk) begin
    if (rst) lenw <= '0;
    else if (state == ST_PAD && pad_done && lenw != 2'd2) lenw <= lenw + 2'd1;
    else lenw <= '0;
  end

  assert property (@(posedge clk) disable iff (rst) core_start |-> !core_busy);
  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> !core_busy);
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.digest_word) &&
                                      $stable(out_ch.word_index));
endmodule

### src/sha384_core.sv
// sha384_core: 80-round compression, one round per cycle on a shared round unit
// depends on sha384_pkg
module sha384_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     load_w,
  input  logic [3:0]               load_idx,
  input  sha384_pkg::word_t        load_data,
  input  logic                     restart,
  output logic                     busy,
  output logic                     done,
  input  logic [2:0]               rd_idx,
  output sha384_pkg::word_t        rd_data
);
  import sha384_pkg::*;

  word_t      hv [8];
  word_t      wv [8];
  word_t      win [16];
  logic [6:0] t;
  logic       run;
  logic       fold;

  word_t w15, w2, w9, s0, s1, wnew, wt, a, e, b0, b1, mj, ch, sum1, sum2;

  always_comb begin
    w15  = win[4'(t + 7'd1)];
    w2   = win[4'(t + 7'd14)];
    w9   = win[4'(t + 7'd9)];
    s0   = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
    s1   = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
    wnew = win[t[3:0]] + s0 + w9 + s1;
    wt   = (t >= 7'd16) ? wnew : win[t[3:0]];
    a    = wv[0];
    e    = wv[4];
    b0   = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
    b1   = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
    mj   = (a & wv[1]) ^ (a & wv[2]) ^ (wv[1] & wv[2]);
    ch   = (e & wv[5]) ^ (~e & wv[6]);
    sum1 = b0 + mj;
    sum2 = round_k(t) + wt + b1 + ch + wv[7];
  end

  assign busy    = run | fold;
  assign rd_data = hv[rd_idx];

  // fold completes in the cycle before done
  always_ff @(posedge clk) begin
    done <= fold && !run && !start && !(rst || restart);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      run  <= 1'b0;
      fold <= 1'b0;
      for (int j = 0; j < 8; j++) hv[j] <= init_hash(3'(j));
    end else if (start) begin
      run <= 1'b1;
      t   <= '0;
      for (int j = 0; j < 8; j++) wv[j] <= hv[j];
    end else if (run) begin
      win[t[3:0]] <= wt;
      wv[0] <= sum1 + sum2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + sum2;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
      if (t == 7'(Rounds - 1)) begin
        run  <= 1'b0;
        fold <= 1'b1;
      end
      t <= t + 7'd1;
    end else if (fold) begin
      for (int j = 0; j < 8; j++) hv[j] <= hv[j] + wv[j];
      fold <= 1'b0;
    end
    if (load_w) win[load_idx] <= load_data;
  end

  assert property (@(posedge clk) disable iff (rst) start |=> run);
  assert property (@(posedge clk) disable iff (rst) run && t == 7'(Rounds - 1) |=> fold);
  assert property (@(posedge clk) disable iff (rst) done |-> !run);
endmodule
